>>> sv/sobel_pkg.sv
// shared types and constants for the sobel edge magnitude block
package sobel_pkg;

  localparam int PIXEL_W   = 24;
  localparam int CH_W      = 8;
  localparam int CHANNELS  = 3;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int GRAD_W    = 11;
  localparam int SUM_W     = 21;
  localparam int ROOT_BW   = $clog2(CH_W);

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [CH_W-1:0]  MAG_MAX  = 8'd255;
  localparam logic [SUM_W-1:0] SQ_LIMIT = 21'd65280;

  typedef struct packed {
    logic               accept;
    logic               load;
    logic               square;
    logic               root_step;
    logic [ROOT_BW-1:0] root_bit;
    logic               out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } sts_t;

endpackage

>>> sv/sobel_ctrl.sv
// sequencer for the sobel edge magnitude block
module sobel_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sobel_pkg::sts_t   sts_i,
  output sobel_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SQUARE,
    S_ROOT,
    S_FINISH
  } state_e;

  state_e                         state_q;
  logic [sobel_pkg::ROOT_BW-1:0]  bit_q;
  logic                           out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.root_bit = bit_q;
    in_stall_o     = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE:   cmd_o.accept    = in_valid_i;
      S_LOAD:   cmd_o.load      = 1'b1;
      S_SQUARE: cmd_o.square    = 1'b1;
      S_ROOT:   cmd_o.root_step = 1'b1;
      S_FINISH: cmd_o.out_load  = !out_valid_q || !out_stall_i;
      default:  cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_LOAD;
        end
        S_LOAD: begin
          state_q <= sts_i.emit ? S_SQUARE : S_IDLE;
        end
        S_SQUARE: begin
          bit_q   <= sobel_pkg::ROOT_BW'(sobel_pkg::CH_W - 1);
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (bit_q == '0) begin
            state_q <= S_FINISH;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_FINISH: begin
          if (cmd_o.out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/sobel_datapath.sv
// line stores, window, gradient, square root and output register
module sobel_datapath #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sobel_pkg::cmd_t                     cmd_i,
  output sobel_pkg::sts_t                     sts_o,
  input  logic                                cfg_we_i,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sobel_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                                action_i,
  input  logic [sobel_pkg::PIXEL_W-1:0]       pixel_i,
  output logic [sobel_pkg::PIXEL_W-1:0]       edge_pixel_o,
  output logic                                last_pixel_o
);

  localparam int PW  = sobel_pkg::PIXEL_W;
  localparam int CW  = sobel_pkg::CH_W;
  localparam int GW  = sobel_pkg::GRAD_W;
  localparam int SW  = sobel_pkg::SUM_W;
  localparam int NC  = sobel_pkg::CHANNELS;
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int CWW = ((EW > sobel_pkg::DIM_W) ? EW : sobel_pkg::DIM_W) + 1;
  localparam int RW  = $clog2(MAX_HEIGHT + 4);
  localparam int HCW = ((RW > sobel_pkg::DIM_W) ? RW : sobel_pkg::DIM_W) + 1;

  logic [sobel_pkg::DIM_W-1:0] cfg_w_q, cfg_h_q;
  logic [AW-1:0]  in_col_q, out_col_q;
  logic [RW-1:0]  in_row_q, out_row_q;
  logic [CWW-1:0] w_ext, eff_w;
  logic [HCW-1:0] h_ext, eff_h;

  logic [2*PW-1:0] mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_q;
  logic [PW-1:0]   v_q;
  logic [PW-1:0]   win_q [2][3];
  logic [PW-1:0]   col [3];
  logic [PW-1:0]   view [3][3];

  logic [AW-1:0]  c, in_col_d, out_col_d;
  logic [RW-1:0]  in_row_d, out_row_d;
  logic           c_first, c_end, emit, last, clear;
  logic           out_first_row, out_last_row, out_first_col, out_last_col;
  logic           last_q, last_out_q;

  logic signed [GW-1:0] gx_d [NC];
  logic signed [GW-1:0] gy_d [NC];
  logic signed [GW-1:0] gx_q [NC];
  logic signed [GW-1:0] gy_q [NC];
  logic [SW-1:0]        s_d [NC];
  logic [SW-1:0]        s_q [NC];
  logic [CW-1:0]        root_d [NC];
  logic [CW-1:0]        root_q [NC];
  logic [CW-1:0]        mag [NC];
  logic [PW-1:0]        edge_q;

  // effective image size
  always_comb begin
    w_ext = CWW'(cfg_w_q);
    h_ext = HCW'(cfg_h_q);
    if (w_ext == '0) begin
      eff_w = CWW'(1);
    end else if (w_ext > CWW'(MAX_WIDTH)) begin
      eff_w = CWW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    if (h_ext == '0) begin
      eff_h = HCW'(1);
    end else if (h_ext > HCW'(MAX_HEIGHT)) begin
      eff_h = HCW'(MAX_HEIGHT);
    end else begin
      eff_h = h_ext;
    end
  end

  // position and window control
  always_comb begin
    c             = (CWW'(in_col_q) >= eff_w) ? '0 : in_col_q;
    c_first       = (c == '0);
    c_end         = (CWW'(c) + CWW'(1) >= eff_w);
    emit          = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && !c_first);
    out_first_row = (out_row_q == '0);
    out_last_row  = (HCW'(out_row_q) + HCW'(1) >= eff_h);
    out_first_col = (out_col_q == '0);
    out_last_col  = (CWW'(out_col_q) + CWW'(1) >= eff_w);
    last          = emit && out_last_row && out_last_col;

    if (c_end) begin
      in_col_d = '0;
      in_row_d = in_row_q + RW'(1);
    end else begin
      in_col_d = c + AW'(1);
      in_row_d = in_row_q;
    end
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (emit) begin
      if (out_last_col) begin
        out_col_d = '0;
        out_row_d = out_row_q + RW'(1);
      end else begin
        out_col_d = out_col_q + AW'(1);
      end
    end
    clear = last || (HCW'(in_row_d) > eff_h + HCW'(2));
  end

  assign sts_o.emit = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= sobel_pkg::DIM_W'(1);
      cfg_h_q   <= sobel_pkg::DIM_W'(1);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sobel_pkg::REG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i;
        sobel_pkg::REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i;
        default:                     cfg_w_q <= cfg_w_q;
      endcase
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cmd_i.load) begin
      if (clear) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  // line stores: upper row in the high half, middle row in the low half
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= mem[c];
    end
    if (cmd_i.load) begin
      mem[c] <= {rd_q[PW-1:0], v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      v_q <= ((action_i == sobel_pkg::ACT_PIXEL) && (HCW'(in_row_q) < eff_h)) ? pixel_i : '0;
    end
  end

  always_comb begin
    col[0] = rd_q[2*PW-1:PW];
    col[1] = rd_q[PW-1:0];
    col[2] = v_q;
    for (int j = 0; j < 3; j++) begin
      view[0][j] = win_q[0][j];
      view[1][j] = win_q[1][j];
      view[2][j] = c_first ? '0 : col[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.load) begin
      for (int j = 0; j < 3; j++) begin
        win_q[0][j] <= c_first ? '0 : view[1][j];
        win_q[1][j] <= c_first ? col[j] : view[2][j];
      end
    end
  end

  // per channel gradient, square sum, square root and rounding
  for (genvar ch = 0; ch < NC; ch++) begin : g_chan
    logic signed [GW-1:0]   pv [3][3];
    logic signed [2*GW-1:0] gx2, gy2, sq_full;
    logic [CW-1:0]          trial;
    logic [2*CW-1:0]        trial_sq;
    logic [2*CW:0]          bound;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((j == 0 && out_first_row) || (j == 2 && out_last_row) ||
              (i == 0 && out_first_col) || (i == 2 && out_last_col)) begin
            pv[i][j] = '0;
          end else begin
            pv[i][j] = signed'(GW'(view[i][j][ch*CW +: CW]));
          end
        end
      end
      gx_d[ch] = (pv[2][0] - pv[0][0]) + ((pv[2][1] - pv[0][1]) <<< 1)
               + (pv[2][2] - pv[0][2]);
      gy_d[ch] = (pv[0][2] - pv[0][0]) + ((pv[1][2] - pv[1][0]) <<< 1)
               + (pv[2][2] - pv[2][0]);
    end

    always_comb begin
      gx2     = gx_q[ch] * gx_q[ch];
      gy2     = gy_q[ch] * gy_q[ch];
      sq_full = gx2 + gy2;
      s_d[ch] = sq_full[SW-1:0];

      trial    = root_q[ch] | (CW'(1) << cmd_i.root_bit);
      trial_sq = trial * trial;
      root_d[ch] = (SW'(trial_sq) <= s_q[ch]) ? trial : root_q[ch];

      bound = (2*CW+1)'(root_q[ch]) * (2*CW+1)'(root_q[ch]) + (2*CW+1)'(root_q[ch]);
      if (s_q[ch] > sobel_pkg::SQ_LIMIT) begin
        mag[ch] = sobel_pkg::MAG_MAX;
      end else if (s_q[ch] > SW'(bound)) begin
        mag[ch] = root_q[ch] + CW'(1);
      end else begin
        mag[ch] = root_q[ch];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
      if (cmd_i.square) begin
        s_q[ch]    <= s_d[ch];
        root_q[ch] <= '0;
      end else if (cmd_i.root_step) begin
        root_q[ch] <= root_d[ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= last;
    end
    if (cmd_i.out_load) begin
      edge_q     <= {mag[2], mag[1], mag[0]};
      last_out_q <= last_q;
    end
  end

  assign edge_pixel_o = edge_q;
  assign last_pixel_o = last_out_q;

endmodule

>>> sv/sobel_edge_magnitude_core.sv
// top level of the sobel edge magnitude block
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i/in_stall_o   action_i, pixel_i
//   output    out        out_valid_o/out_stall_i edge_pixel_o, last_pixel_o
//   config    in         cfg_we_i                cfg_index_i, cfg_data_i
//
// an item without a result runs idle and load; one with a result adds square, the
// 8-step bit-serial square root and finish, plus any wait for the output register
// line stores are read one cycle and written the next through a single memory port
// reset clears counters and window, sets size to 1x1; line stores need no clearing pass
// a new transaction is taken while a finished result waits in the output register
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sobel_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [sobel_pkg::PIXEL_W-1:0]    pixel_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sobel_pkg::PIXEL_W-1:0]    edge_pixel_o,
  output logic                             last_pixel_o
);

  sobel_pkg::cmd_t cmd;
  sobel_pkg::sts_t sts;

  sobel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sobel_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .pixel_i      (pixel_i),
    .edge_pixel_o (edge_pixel_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

>>> sv/sobel_checker.sv
// port checks for the sobel edge magnitude block and their binding
module sobel_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [sobel_pkg::PIXEL_W-1:0] edge_pixel_o,
  input logic                          last_pixel_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(edge_pixel_o) && $stable(last_pixel_o))
    else $error("result payload changed while stalled");

  // one transaction at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous transaction in work");

  // a new result is only loaded at the end of work on a transaction
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work");

endmodule

bind sobel_edge_magnitude_core sobel_checker u_sobel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .edge_pixel_o (edge_pixel_o),
  .last_pixel_o (last_pixel_o)
);

>>> sim/tb_sobel_edge_magnitude_core.sv
// testbench for sobel_edge_magnitude_core: random rgb images checked against a built-in predictor
module tb_sobel_edge_magnitude_core;

  localparam int IDLE_GAP = 24;

  class sobel_magnitude_board;
    logic [sobel_pkg::DIM_W-1:0]   width_reg;
    logic [sobel_pkg::DIM_W-1:0]   height_reg;
    logic [sobel_pkg::PIXEL_W-1:0] upper_row [sobel_pkg::DEF_MAX_WIDTH];
    logic [sobel_pkg::PIXEL_W-1:0] middle_row [sobel_pkg::DEF_MAX_WIDTH];
    logic [sobel_pkg::PIXEL_W-1:0] win [3][3];
    int unsigned                   in_col, in_row, out_col, out_row;
    logic [sobel_pkg::PIXEL_W:0]   expected_edges [$];
    int                            errors;
    int                            checked;

    function new();
      width_reg  = 1;
      height_reg = 1;
      foreach (upper_row[k]) begin
        upper_row[k]  = '0;
        middle_row[k] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      errors  = 0;
      checked = 0;
      clear_position();
    endfunction

    function void clear_position();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > sobel_pkg::DEF_MAX_WIDTH) return sobel_pkg::DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > sobel_pkg::DEF_MAX_HEIGHT) return sobel_pkg::DEF_MAX_HEIGHT;
      return height_reg;
    endfunction

    function int pending();
      return expected_edges.size();
    endfunction

    function void write_register(logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                                 logic [sobel_pkg::DIM_W-1:0] val);
      if (idx == sobel_pkg::REG_IMAGE_WIDTH) width_reg = val;
      else if (idx == sobel_pkg::REG_IMAGE_HEIGHT) height_reg = val;
      else return;
      clear_position();
    endfunction

    // rounded integer root of gx^2 + gy^2, clamped to one channel
    function logic [sobel_pkg::CH_W-1:0] edge_mag(int gx, int gy);
      int unsigned s, r, t;
      s = gx * gx + gy * gy;
      if (s > sobel_pkg::SQ_LIMIT) return sobel_pkg::MAG_MAX;
      r = 0;
      for (int b = sobel_pkg::CH_W - 1; b >= 0; b--) begin
        t = r | (1 << b);
        if (t * t <= s) r = t;
      end
      if (s > r * r + r) r++;
      return (r > sobel_pkg::MAG_MAX) ? sobel_pkg::MAG_MAX : r[sobel_pkg::CH_W-1:0];
    endfunction

    function void note_pixel(logic act, logic [sobel_pkg::PIXEL_W-1:0] px);
      int unsigned                   w, h, c, r;
      logic [sobel_pkg::PIXEL_W-1:0] v;
      logic [sobel_pkg::PIXEL_W-1:0] column [3];
      logic [sobel_pkg::PIXEL_W-1:0] view [3][3];
      logic [sobel_pkg::PIXEL_W-1:0] result;
      logic                          emit, last;
      int                            gx, gy, p;
      w = eff_w();
      h = eff_h();
      c = in_col;
      r = in_row;
      if (c >= w) c = 0;
      v = (act == sobel_pkg::ACT_PIXEL && r < h) ? px : '0;
      column[0] = upper_row[c];
      column[1] = middle_row[c];
      column[2] = v;
      upper_row[c]  = middle_row[c];
      middle_row[c] = v;
      for (int j = 0; j < 3; j++) begin
        view[0][j] = win[1][j];
        view[1][j] = win[2][j];
        view[2][j] = (c == 0) ? '0 : column[j];
      end
      for (int j = 0; j < 3; j++) begin
        if (c == 0) begin
          win[0][j] = '0;
          win[1][j] = '0;
          win[2][j] = column[j];
        end else begin
          for (int i = 0; i < 3; i++) win[i][j] = view[i][j];
        end
      end
      emit = (r >= 2) || (r == 1 && c >= 1);
      last = 1'b0;
      if (emit) begin
        result = '0;
        for (int ch = 0; ch < sobel_pkg::CHANNELS; ch++) begin
          gx = 0;
          gy = 0;
          for (int j = 0; j < 3; j++) begin
            if ((j == 0 && out_row == 0) || (j == 2 && out_row + 1 >= h)) continue;
            for (int i = 0; i < 3; i++) begin
              if ((i == 0 && out_col == 0) || (i == 2 && out_col + 1 >= w)) continue;
              p = view[i][j][sobel_pkg::CH_W*ch +: sobel_pkg::CH_W];
              gx += p * (i - 1) * ((j == 1) ? 2 : 1);
              gy += p * (j - 1) * ((i == 1) ? 2 : 1);
            end
          end
          result[sobel_pkg::CH_W*ch +: sobel_pkg::CH_W] = edge_mag(gx, gy);
        end
        last = (out_row + 1 >= h) && (out_col + 1 >= w);
        expected_edges.push_back({last, result});
        if (out_col + 1 >= w) begin
          out_col = 0;
          out_row++;
        end else begin
          out_col++;
        end
      end
      if (c + 1 >= w) begin
        in_col = 0;
        in_row = r + 1;
      end else begin
        in_col = c + 1;
      end
      if (last || in_row > h + 2) clear_position();
    endfunction

    function void check_edge_result(logic [sobel_pkg::PIXEL_W-1:0] edge_px, logic last_px);
      logic [sobel_pkg::PIXEL_W:0] exp_item;
      checked++;
      if (expected_edges.size() == 0) begin
        $error("unexpected transaction: edge_pixel %h last_pixel %b", edge_px, last_px);
        errors++;
        return;
      end
      exp_item = expected_edges.pop_front();
      if (edge_px !== exp_item[sobel_pkg::PIXEL_W-1:0]) begin
        $error("edge_pixel: expected %h actual %h", exp_item[sobel_pkg::PIXEL_W-1:0], edge_px);
        errors++;
      end
      if (last_px !== exp_item[sobel_pkg::PIXEL_W]) begin
        $error("last_pixel: expected %b actual %b", exp_item[sobel_pkg::PIXEL_W], last_px);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index = sobel_pkg::REG_IMAGE_WIDTH;
  logic [sobel_pkg::DIM_W-1:0]     cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            action = sobel_pkg::ACT_PIXEL;
  logic [sobel_pkg::PIXEL_W-1:0]   pixel = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [sobel_pkg::PIXEL_W-1:0]   edge_px;
  logic                            last_px;

  sobel_magnitude_board board = new();

  int items_sent = 0;
  int images_sent = 0;
  int settings_used = 0;
  int long_hold = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  sobel_edge_magnitude_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .pixel_i      (pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .edge_pixel_o (edge_px),
    .last_pixel_o (last_px)
  );

  always #4 clk = ~clk;

  function automatic logic [sobel_pkg::PIXEL_W-1:0] random_pixel();
    logic [sobel_pkg::PIXEL_W-1:0] px;
    px = $urandom();
    if ($urandom_range(0, 2) == 0) begin
      for (int ch = 0; ch < sobel_pkg::CHANNELS; ch++)
        px[sobel_pkg::CH_W*ch +: sobel_pkg::CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic act, input logic [sobel_pkg::PIXEL_W-1:0] px);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    pixel    = px;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_pixel(act, px);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sobel_pkg::DIM_W-1:0] val);
    settle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    board.write_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_size(input logic [sobel_pkg::DIM_W-1:0] w,
                          input logic [sobel_pkg::DIM_W-1:0] h);
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, w);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, h);
    settings_used++;
  endtask

  task automatic send_image(input int w, input int h, input int noise_pct, input int pause_at);
    logic act;
    for (int k = 0; k < w * h; k++) begin
      if (k == pause_at) settle();
      act = ($urandom_range(1, 100) <= noise_pct) ? sobel_pkg::ACT_FLUSH : sobel_pkg::ACT_PIXEL;
      send_item(act, random_pixel());
    end
    for (int k = 0; k <= w; k++) begin
      act = ($urandom_range(1, 100) <= noise_pct) ? sobel_pkg::ACT_PIXEL : sobel_pkg::ACT_FLUSH;
      send_item(act, random_pixel());
    end
    images_sent++;
  endtask

  initial begin : result_sink
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        out_stall = 1'b1;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      n = out_quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      board.check_edge_result(edge_px, last_px);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int phase, w, h, start, random_items, noise, pause_at;
    bit big;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // size after reset is one by one
    send_item(sobel_pkg::ACT_PIXEL, 24'hFFFFFF);
    send_item(sobel_pkg::ACT_FLUSH, 24'h000000);
    send_item(sobel_pkg::ACT_FLUSH, 24'hFFFFFF);

    set_size(3, 2);
    send_item(sobel_pkg::ACT_PIXEL, 24'hFFFFFF);
    send_item(sobel_pkg::ACT_PIXEL, 24'h000000);
    send_item(sobel_pkg::ACT_PIXEL, 24'hFFFFFF);
    send_item(sobel_pkg::ACT_FLUSH, 24'hFFFFFF);
    send_item(sobel_pkg::ACT_PIXEL, 24'h00FF00);
    send_item(sobel_pkg::ACT_PIXEL, 24'hFF00FF);
    send_item(sobel_pkg::ACT_PIXEL, 24'h123456);
    repeat (3) send_item(sobel_pkg::ACT_FLUSH, 24'h000000);

    // partial image, dropped by the next size write
    set_size(4, 3);
    for (int k = 0; k < 6; k++) send_item(sobel_pkg::ACT_PIXEL, random_pixel());

    random_items = 0;
    phase = 0;
    while (random_items < 650 || phase < 5) begin
      phase++;
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      big = 1'b0;
      pause_at = -1;
      start = items_sent;
      case (phase)
        2: begin
          set_size(11'd2047, 11'd1);
          big = 1'b1;
        end
        3: begin
          set_size(8, 6);
          long_hold = 300;
        end
        4: begin
          set_size(6, 5);
          pause_at = 15;
        end
        5: begin
          set_size(11'd0, 11'd2047);
          big = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 12);
          end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
          end
          set_size(w, h);
        end
      endcase
      w = board.eff_w();
      h = board.eff_h();
      if (big) begin
        // start of a clamped image, dropped by the next size write
        repeat (60) send_item(sobel_pkg::ACT_PIXEL, random_pixel());
      end else begin
        repeat ($urandom_range(1, 3)) begin
          noise = ($urandom_range(0, 3) == 0) ? 10 : 0;
          send_image(w, h, noise, pause_at);
          pause_at = -1;
        end
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, w * h)) send_item(sobel_pkg::ACT_PIXEL, random_pixel());
        end
      end
      random_items += items_sent - start;
    end

    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("sent %0d input transactions (%0d full images, %0d size settings)",
             items_sent, images_sent, settings_used);
    $display("checked %0d result transactions, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
sv/sobel_pkg.sv
sv/sobel_ctrl.sv
sv/sobel_datapath.sv
sv/sobel_edge_magnitude_core.sv
sv/sobel_checker.sv
sim/tb_sobel_edge_magnitude_core.sv
